// ===== hdl/optimal_bst_solver_assert.svh =====
// assertion macros for the optimal bst solver checker
`ifndef OPTIMAL_BST_SOLVER_ASSERT_SVH
`define OPTIMAL_BST_SOLVER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OBST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define OBST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/obst_pkg.sv =====
// shared constants and types of the optimal bst solver
`timescale 1ns / 1ps
package obst_pkg;

   localparam int MAX_KEYS_DEF    = 32;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int KEY_BITS_DEF    = 32;

   localparam int COST_BITS = 32;
   localparam int ROOT_BITS = 6;

   localparam logic [1:0] ACT_LOAD_KEY = 2'd0;
   localparam logic [1:0] ACT_LOAD_GAP = 2'd1;
   localparam logic [1:0] ACT_SOLVE    = 2'd2;

   // tag that travels with one root candidate through the cost pipe
   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      logic [ROOT_BITS-1:0] root;
   } cand_tag_type;

endpackage

// ===== hdl/optimal_bst_solver.sv =====
// optimal binary search tree solver top level
//
//   channel  dir  handshake              content
//   req      in   req_tvalid/req_tready  key, weight and solve words
//   rsp      out  rsp_tvalid/rsp_tready  one word per tree node, breadth first
//   csr      in   apb, pready tied high  key_count at byte address 0
//
// loads are accepted while idle and the block stays ready for the next word
// a solve first seeds the zero-length ranges, then for each key range issues
// one root candidate after another, drains the candidate pipe and writes the
// table; the range table memory with its two read ports feeds each candidate
// the tree walk handles one node at a time and holds while rsp stalls
// reset clears control state only; tables are written before they are read
`timescale 1ns / 1ps
module optimal_bst_solver #(
   parameter int MAX_KEYS    = obst_pkg::MAX_KEYS_DEF,
   parameter int WEIGHT_BITS = obst_pkg::WEIGHT_BITS_DEF,
   parameter int KEY_BITS    = obst_pkg::KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // index[5:0], weight[21:6], key_value[53:22], zero
   input  logic [1:0]  req_tuser,   // action
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // total_cost[31:0], tree_position[63:32], key_out[95:64]
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import obst_pkg::*;

   localparam int DIM    = MAX_KEYS + 1;
   localparam int TDEPTH = DIM * DIM;
   localparam int TA     = $clog2(TDEPTH);
   localparam int KI     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int GI     = $clog2(DIM);
   localparam int CW     = $clog2(MAX_KEYS + 1);
   localparam int SW     = WEIGHT_BITS + 7;
   localparam int TW     = ROOT_BITS + COST_BITS + SW;
   localparam int QD     = 64;
   localparam int QA     = $clog2(QD);
   localparam int QW     = 32 + 2 * CW;

   localparam logic [2:0] CSR_KEY_COUNT = 3'd0;

   typedef enum logic [12:0] {
      ST_IDLE       = 13'b0000000000001,
      ST_INIT       = 13'b0000000000010,
      ST_INIT_END   = 13'b0000000000100,
      ST_FILL_ISSUE = 13'b0000000001000,
      ST_FILL_DRAIN = 13'b0000000010000,
      ST_FILL_WRITE = 13'b0000000100000,
      ST_WALK_START = 13'b0000001000000,
      ST_WALK_TOT   = 13'b0000010000000,
      ST_WALK_POP   = 13'b0000100000000,
      ST_WALK_CHK   = 13'b0001000000000,
      ST_WALK_ROOT  = 13'b0010000000000,
      ST_WALK_KEY   = 13'b0100000000000,
      ST_WALK_PUSH  = 13'b1000000000000
   } state_type;

   // range table address: length row times DIM plus start
   function automatic logic [TA-1:0] taddr(input logic [CW-1:0] l, input logic [CW-1:0] st);
      return TA'(int'(l) * DIM + int'(st));
   endfunction

   // input word fields
   logic [5:0]         req_index;
   logic [15:0]        req_weight;
   logic signed [31:0] req_key;
   logic               req_fire;

   assign req_index  = req_tdata[5:0];
   assign req_weight = req_tdata[21:6];
   assign req_key    = signed'(req_tdata[53:22]);
   assign req_fire   = req_tvalid && req_tready;

   // configuration
   logic [5:0]    key_count_ff;
   logic [CW-1:0] n_keys;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_KEY_COUNT) ? 32'(key_count_ff) : 32'd0;
   assign n_keys     = (int'(key_count_ff) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= 6'd1;
      end else if (csr_wr && (csr_paddr == CSR_KEY_COUNT)) begin
         key_count_ff <= csr_pwdata[5:0];
      end
   end

   // control registers
   state_type       state_ff, state_in;
   logic [CW-1:0]   len_ff, len_in;
   logic [CW-1:0]   s_ff, s_in;
   logic [CW-1:0]   r_ff, r_in;
   logic            init_v_ff, init_v_in;
   logic [CW-1:0]   init_s_ff;
   logic [QA:0]     head_ff, head_in;
   logic [QA:0]     tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   root_ff, root_in;
   logic [31:0]     pos_ff;
   logic [CW-1:0]   ent_start_ff, ent_end_ff;
   logic [COST_BITS-1:0] total_ff;
   logic            cap_ent, cap_total;

   // key / success weight store and gap weight store
   logic signed [KEY_BITS-1:0] key_mem [MAX_KEYS];
   logic [WEIGHT_BITS-1:0]     hit_mem [MAX_KEYS];
   logic [WEIGHT_BITS-1:0]     gap_mem [DIM];
   logic signed [KEY_BITS-1:0] key_rd_ff;
   logic [WEIGHT_BITS-1:0]     hit_rd_ff;
   logic [WEIGHT_BITS-1:0]     gap_rd_ff;
   logic [KI-1:0]              kaddr;
   logic [GI-1:0]              gaddr;

   // walk queue
   logic [QW-1:0] q_mem [QD];
   logic [QW-1:0] q_rd_ff;
   logic          q_we;
   logic [QW-1:0] q_wdata;
   logic [31:0]   q_pos;
   logic [CW-1:0] q_start, q_end;

   assign q_pos   = q_rd_ff[31:0];
   assign q_start = q_rd_ff[32 +: CW];
   assign q_end   = q_rd_ff[32 + CW +: CW];

   // range table
   logic          t_we;
   logic [TA-1:0] t_waddr;
   logic [TW-1:0] t_wdata;
   logic [TA-1:0] t_raddr_a, t_raddr_b;
   logic [TW-1:0] t_rd_a, t_rd_b;
   logic [ROOT_BITS-1:0] rd_root;

   assign rd_root = t_rd_a[TW-1 -: ROOT_BITS];

   // candidate pipe
   cand_tag_type         tag_issue;
   logic [SW-1:0]        best_w;
   logic [COST_BITS-1:0] best_c;
   logic [ROOT_BITS-1:0] best_r;
   logic                 cand_done;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        out_free, out_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign req_tready = (state_ff == ST_IDLE);

   // loads and registered reads of the small stores
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == ACT_LOAD_KEY) && (int'(req_index) < MAX_KEYS)) begin
         key_mem[req_index[KI-1:0]] <= KEY_BITS'(req_key);
         hit_mem[req_index[KI-1:0]] <= WEIGHT_BITS'(req_weight);
      end
      if (req_fire && (req_tuser == ACT_LOAD_GAP) && (int'(req_index) <= MAX_KEYS)) begin
         gap_mem[req_index[GI-1:0]] <= WEIGHT_BITS'(req_weight);
      end
      key_rd_ff <= key_mem[kaddr];
      hit_rd_ff <= hit_mem[kaddr];
      gap_rd_ff <= gap_mem[gaddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff[QA-1:0]] <= q_wdata;
      end
      q_rd_ff <= q_mem[head_ff[QA-1:0]];
   end

   // key store read: candidate hit weight while filling, chosen root while walking
   always_comb begin
      if (state_ff == ST_FILL_ISSUE) begin
         kaddr = KI'(s_ff + r_ff);
      end else if (state_ff == ST_WALK_ROOT) begin
         kaddr = KI'(CW'(rd_root) - CW'(1));
      end else begin
         kaddr = KI'(root_ff - CW'(1));
      end
   end

   assign gaddr = GI'(s_ff);

   // table read ports
   always_comb begin
      t_raddr_a = taddr(r_ff, s_ff);
      t_raddr_b = taddr(len_ff - r_ff - CW'(1), s_ff + r_ff + CW'(1));
      if (state_ff == ST_WALK_START) begin
         t_raddr_a = taddr(n_keys, CW'(0));
      end else if (state_ff == ST_WALK_CHK) begin
         t_raddr_a = taddr(q_end - q_start, q_start);
      end
   end

   // table write: zero-length seeds, then chosen range results
   always_comb begin
      t_we    = 1'b0;
      t_waddr = taddr(CW'(0), init_s_ff);
      t_wdata = {ROOT_BITS'(0), COST_BITS'(0), SW'(gap_rd_ff)};
      if (init_v_ff) begin
         t_we = 1'b1;
      end else if (state_ff == ST_FILL_WRITE) begin
         t_we    = 1'b1;
         t_waddr = taddr(len_ff, s_ff);
         t_wdata = {best_r, best_c, best_w};
      end
   end

   obst_table_ram #(
      .WIDTH (TW),
      .DEPTH (TDEPTH),
      .AW    (TA)
   ) u_table (
      .clock     (clock),
      .wr_en     (t_we),
      .wr_addr   (t_waddr),
      .wr_data   (t_wdata),
      .rd_a_addr (t_raddr_a),
      .rd_b_addr (t_raddr_b),
      .rd_a_data (t_rd_a),
      .rd_b_data (t_rd_b)
   );

   always_comb begin
      tag_issue.valid = (state_ff == ST_FILL_ISSUE);
      tag_issue.first = (r_ff == CW'(0));
      tag_issue.last  = (r_ff == len_ff - CW'(1));
      tag_issue.root  = ROOT_BITS'(s_ff + r_ff + CW'(1));
   end

   obst_cand_pipe #(
      .SW (SW)
   ) u_cand (
      .clock        (clock),
      .reset        (reset),
      .tag_in       (tag_issue),
      .left_weight  (t_rd_a[SW-1:0]),
      .left_cost    (t_rd_a[SW +: COST_BITS]),
      .right_weight (t_rd_b[SW-1:0]),
      .right_cost   (t_rd_b[SW +: COST_BITS]),
      .hit          (SW'(hit_rd_ff)),
      .best_weight  (best_w),
      .best_cost    (best_c),
      .best_root    (best_r),
      .done         (cand_done)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      init_v_in    = 1'b0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      root_in      = root_ff;
      cap_ent      = 1'b0;
      cap_total    = 1'b0;
      out_load     = 1'b0;
      q_we         = 1'b0;
      q_wdata      = {ent_end_ff, root_ff, pos_ff[30:0], 1'b1};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == ACT_SOLVE) && (n_keys != CW'(0))) begin
               // walk queue starts empty at slot zero
               s_in     = CW'(0);
               head_in  = '0;
               tail_in  = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // seed row zero: gap weight, zero cost, no root
            init_v_in = 1'b1;
            if (s_ff == n_keys) begin
               state_in = ST_INIT_END;
            end else begin
               s_in = s_ff + CW'(1);
            end
         end
         ST_INIT_END: begin
            len_in   = CW'(1);
            s_in     = CW'(0);
            r_in     = CW'(0);
            state_in = ST_FILL_ISSUE;
         end
         ST_FILL_ISSUE: begin
            if (r_ff == len_ff - CW'(1)) begin
               state_in = ST_FILL_DRAIN;
            end else begin
               r_in = r_ff + CW'(1);
            end
         end
         ST_FILL_DRAIN: begin
            if (cand_done) begin
               state_in = ST_FILL_WRITE;
            end
         end
         ST_FILL_WRITE: begin
            r_in     = CW'(0);
            state_in = ST_FILL_ISSUE;
            if (s_ff == n_keys - len_ff) begin
               s_in = CW'(0);
               if (len_ff == n_keys) begin
                  state_in = ST_WALK_START;
               end else begin
                  len_in = len_ff + CW'(1);
               end
            end else begin
               s_in = s_ff + CW'(1);
            end
         end
         ST_WALK_START: begin
            // whole range goes in first at position one
            q_we     = 1'b1;
            q_wdata  = {n_keys, CW'(0), 32'd1};
            head_in  = '0;
            tail_in  = (QA+1)'(1);
            count_in = CW'(0);
            state_in = ST_WALK_TOT;
         end
         ST_WALK_TOT: begin
            cap_total = 1'b1;
            state_in  = ST_WALK_POP;
         end
         ST_WALK_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_IDLE;
            end else begin
               head_in  = head_ff + (QA+1)'(1);
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            // empty range has no node
            cap_ent = 1'b1;
            if (q_end <= q_start) begin
               state_in = ST_WALK_POP;
            end else begin
               state_in = ST_WALK_ROOT;
            end
         end
         ST_WALK_ROOT: begin
            if (rd_root == ROOT_BITS'(0)) begin
               state_in = ST_WALK_POP;
            end else begin
               root_in  = CW'(rd_root);
               state_in = ST_WALK_KEY;
            end
         end
         ST_WALK_KEY: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               count_in     = count_ff + CW'(1);
               q_we         = 1'b1;
               q_wdata      = {root_ff - CW'(1), ent_start_ff, pos_ff[30:0], 1'b0};
               tail_in      = tail_ff + (QA+1)'(1);
               state_in     = ST_WALK_PUSH;
            end
         end
         ST_WALK_PUSH: begin
            q_we     = 1'b1;
            tail_in  = tail_ff + (QA+1)'(1);
            state_in = ST_WALK_POP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_v_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_v_ff    <= init_v_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      count_ff  <= count_in;
      root_ff   <= root_in;
      init_s_ff <= s_ff;
      if (cap_total) begin
         total_ff <= t_rd_a[SW +: COST_BITS];
      end
      if (cap_ent) begin
         pos_ff       <= q_pos;
         ent_start_ff <= q_start;
         ent_end_ff   <= q_end;
      end
      if (out_load) begin
         rsp_data_ff <= {32'(key_rd_ff), pos_ff, total_ff};
         rsp_last_ff <= (count_ff == n_keys - CW'(1));
      end
   end

endmodule

// ===== hdl/obst_table_ram.sv =====
// range table memory: one write port, two registered read ports
`timescale 1ns / 1ps
module obst_table_ram #(
   parameter int WIDTH = 61,
   parameter int DEPTH = 1089,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_a_addr,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [WIDTH-1:0] rd_a_data,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== hdl/obst_cand_pipe.sv =====
// root candidate pipe: subtree sums, saturated cost and running best
`timescale 1ns / 1ps
module obst_cand_pipe #(
   parameter int SW = 23
) (
   input  logic                           clock,
   input  logic                           reset,
   input  obst_pkg::cand_tag_type         tag_in,
   input  logic [SW-1:0]                  left_weight,
   input  logic [obst_pkg::COST_BITS-1:0] left_cost,
   input  logic [SW-1:0]                  right_weight,
   input  logic [obst_pkg::COST_BITS-1:0] right_cost,
   input  logic [SW-1:0]                  hit,
   output logic [SW-1:0]                  best_weight,
   output logic [obst_pkg::COST_BITS-1:0] best_cost,
   output logic [obst_pkg::ROOT_BITS-1:0] best_root,
   output logic                           done
);
   import obst_pkg::*;

   cand_tag_type         p1_tag_ff, p2_tag_ff;
   logic [SW-1:0]        p2_w_ff, p2_w_in;
   logic [COST_BITS:0]   p2_cs_ff, p2_cs_in;
   logic [COST_BITS+1:0] cand_sum;
   logic [COST_BITS-1:0] cand_cost;
   logic                 take;
   logic [SW-1:0]        best_w_ff;
   logic [COST_BITS-1:0] best_c_ff;
   logic [ROOT_BITS-1:0] best_r_ff;
   logic                 done_ff;

   // stage 1: memory words are here, add weights and child costs
   assign p2_w_in  = left_weight + right_weight + hit;
   assign p2_cs_in = {1'b0, left_cost} + {1'b0, right_cost};

   // stage 2: total cost with saturation, strict compare keeps smallest root
   assign cand_sum  = {1'b0, p2_cs_ff} + (COST_BITS+2)'(p2_w_ff);
   assign cand_cost = (cand_sum[COST_BITS+1:COST_BITS] != 2'b00) ? '1
                                                                  : cand_sum[COST_BITS-1:0];
   assign take      = p2_tag_ff.valid && (p2_tag_ff.first || (cand_cost < best_c_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
         p2_tag_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         p1_tag_ff <= tag_in;
         p2_tag_ff <= p1_tag_ff;
         done_ff   <= p2_tag_ff.valid && p2_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      p2_w_ff  <= p2_w_in;
      p2_cs_ff <= p2_cs_in;
      if (take) begin
         best_w_ff <= p2_w_ff;
         best_c_ff <= cand_cost;
         best_r_ff <= p2_tag_ff.root;
      end
   end

   assign best_weight = best_w_ff;
   assign best_cost   = best_c_ff;
   assign best_root   = best_r_ff;
   assign done        = done_ff;

endmodule

// ===== hdl/obst_checker.sv =====
// port-level checker of the optimal bst solver, bound to the top level
`timescale 1ns / 1ps
`include "optimal_bst_solver_assert.svh"
module obst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tlast
);

   `OBST_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped")
   `OBST_ASSERT_NXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp word changed")
   `OBST_ASSERT_IMP(a_busy_mid, rsp_tvalid && !rsp_tlast, !req_tready, "idle before last node")
   `OBST_ASSERT_NXT(a_busy_next, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready,
      "solve ended without last node")

endmodule

bind optimal_bst_solver obst_checker u_obst_checker (.*);
